// ===== hw/rtl/plq_pkg.sv =====
// ----------------------------------------------------------------------------
// plq_pkg
// Shared types and codes for the price level order queue.
// ----------------------------------------------------------------------------
package plq_pkg;

  // Request codes carried on the input tuser field.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_LIMIT  = 2'd2,
    OP_MARKET = 2'd3
  } op_t;

  // Result status codes carried on the output tuser field.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SLOT_BUSY  = 2'd1,
    ST_NOT_QUEUED = 2'd2
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam int unsigned InBits  = 96;
  localparam int unsigned OutBits = 224;

endpackage

// ===== hw/rtl/price_level_order_queue_top.sv =====
// ----------------------------------------------------------------------------
// price_level_order_queue_top
// One price level of an order book: resting orders kept in arrival order.
// ----------------------------------------------------------------------------
// The level takes requests on the s_ stream channel and returns result words
// on the m_ stream channel. A request word carries its code in s_tuser (add,
// cancel, limit fill, market fill) and the order fields in s_tdata. Add and
// cancel return one word. A fill walks the queue from the head and returns
// one word for every order it touches, or one word when it touches none;
// m_tlast marks the final word of a request.
// Resting orders live in slot-indexed memories (links, ids, volumes) with a
// registered read. Every request word and every fill step runs the same
// sequence: read the entry, update links and totals, add the
// registered volume-times-price product into the notional, present the
// result. A request is accepted only in the idle state after the previous
// one delivered its last word, so the level takes no new request while a
// fill is still walking or a result waits on m_tready. The registered memory
// read and the registered notional product give the sequence its separate
// read and multiply steps.
// Reset empties the level at once: the per-slot queued flags all clear
// together, so there is no clearing pass. While the receiver holds m_tready
// low, the result word stays on m_tdata and the walk waits.
// ----------------------------------------------------------------------------
module price_level_order_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // slot[5:0], order_id[36:6], price[68:37], volume[92:69], side[93], zero pad
  input  logic [plq_pkg::InBits-1:0]   s_tdata,
  // op[1:0]
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // filled_order_id[30:0], filled_slot[36:31], filled_volume[60:37],
  // order_closed[61], leftover_volume[85:62], notional[149:86],
  // level_orders[156:150], level_volume[186:157], level_empty[187],
  // level_price[219:188], zero pad
  output logic [plq_pkg::OutBits-1:0]  m_tdata,
  // status[1:0]
  output logic [1:0]                   m_tuser,
  output logic                         m_tlast
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  plq_pkg::state_t state;

  // Captured request.
  plq_pkg::op_t  op_q;
  logic [5:0]    slot_q;
  logic [30:0]   id_q;
  logic [31:0]   price_q;
  logic [23:0]   req;
  logic          side_q;

  // Level state.
  logic [DEPTH-1:0] queued;
  logic [IW-1:0]    head_idx;
  logic [IW-1:0]    tail_idx;
  logic             head_valid;
  logic [6:0]       count;
  logic [29:0]      total;
  logic [31:0]      level_price;
  logic             level_side;

  // Slot memories.
  logic [IW-1:0] next_mem [DEPTH];
  logic [IW-1:0] prev_mem [DEPTH];
  logic [30:0]   id_mem   [DEPTH];
  logic [23:0]   rem_mem  [DEPTH];
  logic [IW-1:0] rd_next;
  logic [IW-1:0] rd_prev;
  logic [30:0]   rd_id;
  logic [23:0]   rd_rem;
  logic [IW-1:0] rd_addr;

  logic          we_next, we_prev, we_id, we_rem;
  logic [IW-1:0] wa_next, wa_prev, wa_rem;
  logic [IW-1:0] wd_next, wd_prev;
  logic [23:0]   wd_rem;

  // Result staging.
  logic [1:0]  res_status;
  logic [30:0] res_id;
  logic [5:0]  res_slot;
  logic [23:0] res_fv;
  logic        res_closed;
  logic        res_last;
  logic        res_touch;
  logic [55:0] prod;
  logic [63:0] notional;

  // Output register.
  logic [plq_pkg::OutBits-1:0] out_data;
  logic [1:0]                  out_status;
  logic                        out_last;

  // Decode of the current step.
  logic          slot_ok;
  logic [IW-1:0] sidx;
  logic          fill_go;
  logic          closes;
  logic [23:0]   take;
  logic          is_head, is_tail;
  logic          add_first;
  logic [23:0]   req_next;
  logic [29:0]   total_fill;
  logic          more;

  assign s_tready = (state == plq_pkg::S_IDLE);
  assign m_tvalid = (state == plq_pkg::S_OUT);
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  always_comb begin
    slot_ok    = ({1'b0, slot_q} < 7'(DEPTH));
    sidx       = slot_q[IW-1:0];
    fill_go    = (req != 24'd0) && head_valid &&
                 ((op_q == plq_pkg::OP_LIMIT) || (total != 30'd0));
    closes     = (rd_rem <= req);
    take       = closes ? rd_rem : req;
    is_head    = (sidx == head_idx);
    is_tail    = (sidx == tail_idx);
    add_first  = (count == 7'd0) || !head_valid;
    req_next   = req - take;
    total_fill = total - 30'(take);
    more       = closes && (req_next != 24'd0) && (head_idx != tail_idx) &&
                 ((op_q == plq_pkg::OP_LIMIT) || (total_fill != 30'd0));
    rd_addr    = (op_q == plq_pkg::OP_CANCEL) ? sidx : head_idx;

    we_next = 1'b0;
    we_prev = 1'b0;
    we_id   = 1'b0;
    we_rem  = 1'b0;
    wa_next = tail_idx;
    wd_next = sidx;
    wa_prev = sidx;
    wd_prev = tail_idx;
    wa_rem  = sidx;
    wd_rem  = req;
    if (state == plq_pkg::S_EXEC) begin
      unique case (op_q)
        plq_pkg::OP_ADD: begin
          if (slot_ok && !queued[sidx]) begin
            we_id  = 1'b1;
            we_rem = 1'b1;
            if (!add_first) begin
              we_next = 1'b1;
              we_prev = 1'b1;
            end
          end
        end
        plq_pkg::OP_CANCEL: begin
          if (slot_ok && queued[sidx]) begin
            wa_next = rd_prev;
            wd_next = rd_next;
            wa_prev = rd_next;
            wd_prev = rd_prev;
            we_next = !is_head;
            we_prev = !is_tail;
          end
        end
        plq_pkg::OP_LIMIT, plq_pkg::OP_MARKET: begin
          if (fill_go && !closes) begin
            we_rem = 1'b1;
            wa_rem = head_idx;
            wd_rem = rd_rem - take;
          end
        end
      endcase
    end
  end

  // Slot memories: one write and one registered read per array per cycle.
  always_ff @(posedge clk) begin
    if (we_next) next_mem[wa_next] <= wd_next;
    if (we_prev) prev_mem[wa_prev] <= wd_prev;
    if (we_id)   id_mem[sidx]      <= id_q;
    if (we_rem)  rem_mem[wa_rem]   <= wd_rem;
    rd_next <= next_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
    rd_id   <= id_mem[rd_addr];
    rd_rem  <= rem_mem[rd_addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == plq_pkg::S_IDLE && s_tvalid) begin
      op_q     <= plq_pkg::op_t'(s_tuser);
      slot_q   <= s_tdata[5:0];
      id_q     <= s_tdata[36:6];
      price_q  <= s_tdata[68:37];
      req      <= s_tdata[92:69];
      side_q   <= s_tdata[93];
      notional <= 64'd0;
    end
    if (state == plq_pkg::S_EXEC) begin
      res_status <= plq_pkg::ST_OK;
      res_id     <= 31'd0;
      res_slot   <= 6'd0;
      res_fv     <= 24'd0;
      res_closed <= 1'b0;
      res_last   <= 1'b1;
      res_touch  <= 1'b0;
      prod       <= 56'(take) * 56'(level_price);
      unique case (op_q)
        plq_pkg::OP_ADD: begin
          res_id   <= id_q;
          res_slot <= slot_q;
          if (!slot_ok || queued[sidx]) res_status <= plq_pkg::ST_SLOT_BUSY;
        end
        plq_pkg::OP_CANCEL: begin
          res_slot <= slot_q;
          if (slot_ok && queued[sidx]) res_id <= rd_id;
          else res_status <= plq_pkg::ST_NOT_QUEUED;
        end
        plq_pkg::OP_LIMIT, plq_pkg::OP_MARKET: begin
          if (fill_go) begin
            res_id     <= rd_id;
            res_slot   <= 6'(head_idx);
            res_fv     <= take;
            res_closed <= closes;
            res_last   <= !more;
            res_touch  <= 1'b1;
            req        <= req_next;
          end
        end
      endcase
    end
    if (state == plq_pkg::S_MUL) begin
      if (res_touch) begin
        if (op_q == plq_pkg::OP_LIMIT && level_side) begin
          notional <= notional - 64'(prod);
          out_data[149:86] <= notional - 64'(prod);
        end else begin
          notional <= notional + 64'(prod);
          out_data[149:86] <= notional + 64'(prod);
        end
      end else begin
        out_data[149:86] <= 64'd0;
      end
      out_status         <= res_status;
      out_last           <= res_last;
      out_data[30:0]     <= res_id;
      out_data[36:31]    <= res_slot;
      out_data[60:37]    <= res_fv;
      out_data[61]       <= res_closed;
      out_data[85:62]    <= (op_q == plq_pkg::OP_LIMIT || op_q == plq_pkg::OP_MARKET)
                            ? req : 24'd0;
      out_data[156:150]  <= count;
      out_data[186:157]  <= total;
      out_data[187]      <= (total == 30'd0);
      out_data[219:188]  <= level_price;
      out_data[223:220]  <= 4'd0;
    end
  end

  // Control and level state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= plq_pkg::S_IDLE;
      queued      <= '0;
      head_valid  <= 1'b0;
      head_idx    <= '0;
      tail_idx    <= '0;
      count       <= 7'd0;
      total       <= 30'd0;
      level_price <= 32'd0;
      level_side  <= 1'b0;
    end else begin
      unique case (state)
        plq_pkg::S_IDLE: begin
          if (s_tvalid) state <= plq_pkg::S_READ;
        end
        plq_pkg::S_READ: state <= plq_pkg::S_EXEC;
        plq_pkg::S_EXEC: begin
          state <= plq_pkg::S_MUL;
          unique case (op_q)
            plq_pkg::OP_ADD: begin
              if (slot_ok && !queued[sidx]) begin
                if (add_first) begin
                  level_price <= price_q;
                  level_side  <= side_q;
                  head_idx    <= sidx;
                  head_valid  <= 1'b1;
                end
                tail_idx     <= sidx;
                queued[sidx] <= 1'b1;
                count        <= count + 7'd1;
                total        <= total + 30'(req);
              end
            end
            plq_pkg::OP_CANCEL: begin
              if (slot_ok && queued[sidx]) begin
                if (is_head) begin
                  head_idx   <= rd_next;
                  head_valid <= !is_tail;
                end
                if (is_tail) tail_idx <= rd_prev;
                queued[sidx] <= 1'b0;
                count        <= count - 7'd1;
                total        <= total - 30'(rd_rem);
              end
            end
            plq_pkg::OP_LIMIT, plq_pkg::OP_MARKET: begin
              if (fill_go) begin
                total <= total_fill;
                if (closes) begin
                  queued[head_idx] <= 1'b0;
                  count            <= count - 7'd1;
                  head_idx         <= rd_next;
                  head_valid       <= (head_idx != tail_idx);
                end
              end
            end
          endcase
        end
        plq_pkg::S_MUL: state <= plq_pkg::S_OUT;
        plq_pkg::S_OUT: begin
          if (m_tready) state <= out_last ? plq_pkg::S_IDLE : plq_pkg::S_READ;
        end
        default: state <= plq_pkg::S_IDLE;
      endcase
    end
  end

  // The order count tracks the queued flags exactly.
  assert property (@(posedge clk) disable iff (rst) count == 7'($countones(queued)))
    else $error("order count differs from queued slots");

  // A head pointer exists exactly when orders rest.
  assert property (@(posedge clk) disable iff (rst) head_valid == (count != 7'd0))
    else $error("head validity out of step with order count");

  // No request is taken while a result is pending.
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // An unaccepted result holds its word.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

// ===== sim/plq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_checker
// Watches both stream channels of the price level queue, predicts each result
// word from accepted request words and compares them field by field.
// ----------------------------------------------------------------------------
module plq_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [plq_pkg::InBits-1:0]    s_tdata,
  input  logic [1:0]                    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [plq_pkg::OutBits-1:0]   m_tdata,
  input  logic [1:0]                    m_tuser,
  input  logic                          m_tlast,
  output int                            fail_count,
  output int                            pending_words,
  output int                            fill_words
);

  localparam logic [6:0] NIL = 7'd64;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] id;
    logic [5:0]  slot;
    logic [23:0] fvol;
    logic        closed;
    logic [23:0] left;
    logic [63:0] notional;
    logic [6:0]  orders;
    logic [29:0] lvol;
    logic        empty;
    logic [31:0] lprice;
    logic        last;
  } level_word_t;

  level_word_t expected_words[$];

  logic [6:0]  nxt[64];
  logic [6:0]  prv[64];
  logic [30:0] ids[64];
  logic [23:0] rem[64];
  logic        queued[64];
  logic [6:0]  head, tail, count;
  logic [29:0] total;
  logic [31:0] lprice;
  logic        lside;

  assign pending_words = expected_words.size();

  function automatic level_word_t make_word(logic [1:0] st, logic [30:0] id,
      logic [5:0] sl, logic [23:0] fv, logic cl, logic [23:0] lf, logic [63:0] nt);
    level_word_t w;
    w.status = st; w.id = id; w.slot = sl; w.fvol = fv; w.closed = cl;
    w.left = lf; w.notional = nt; w.orders = count; w.lvol = total;
    w.empty = (total == 0); w.lprice = lprice; w.last = 1'b0;
    return w;
  endfunction

  task automatic drop_order(logic [5:0] s);
    if (prv[s] < NIL) nxt[prv[s][5:0]] = nxt[s]; else head = nxt[s];
    if (nxt[s] < NIL) prv[nxt[s][5:0]] = prv[s]; else tail = prv[s];
    queued[s] = 1'b0;
    count = count - 7'd1;
  endtask

  task automatic predict_request(plq_pkg::op_t op, logic [plq_pkg::InBits-1:0] d);
    logic [5:0]  sl;
    logic [30:0] id;
    logic [31:0] pr;
    logic [23:0] vol, req, take;
    logic        sd, cl;
    logic [63:0] nt, prod;
    logic [5:0]  h;
    level_word_t w;
    int          n;
    sl = d[5:0]; id = d[36:6]; pr = d[68:37]; vol = d[92:69]; sd = d[93];
    n = 0;
    case (op)
      plq_pkg::OP_ADD: begin
        if (queued[sl]) begin
          w = make_word(plq_pkg::ST_SLOT_BUSY, id, sl, '0, '0, '0, '0);
        end else begin
          if (count == 0 || head >= NIL) begin
            lprice = pr; lside = sd; head = {1'b0, sl}; prv[sl] = NIL;
          end else begin
            prv[sl] = tail; nxt[tail[5:0]] = {1'b0, sl};
          end
          nxt[sl] = NIL; tail = {1'b0, sl}; ids[sl] = id; rem[sl] = vol;
          queued[sl] = 1'b1; count = count + 7'd1; total = total + vol;
          w = make_word(plq_pkg::ST_OK, id, sl, '0, '0, '0, '0);
        end
        w.last = 1'b1;
        expected_words.push_back(w);
      end
      plq_pkg::OP_CANCEL: begin
        if (!queued[sl]) begin
          w = make_word(plq_pkg::ST_NOT_QUEUED, '0, sl, '0, '0, '0, '0);
        end else begin
          drop_order(sl);
          total = total - rem[sl];
          w = make_word(plq_pkg::ST_OK, ids[sl], sl, '0, '0, '0, '0);
        end
        w.last = 1'b1;
        expected_words.push_back(w);
      end
      default: begin
        req = vol; nt = '0;
        // Market fills also stop once the level holds no volume.
        while (req > 0 && head < NIL && n < 64 &&
               (op == plq_pkg::OP_LIMIT || total > 0)) begin
          h = head[5:0];
          if (rem[h] <= req) begin
            take = rem[h]; cl = 1'b1; drop_order(h);
          end else begin
            take = req; rem[h] = rem[h] - take; cl = 1'b0;
          end
          total = total - take; req = req - take;
          prod = 64'(take) * 64'(lprice);
          if (op == plq_pkg::OP_LIMIT && lside) nt = nt - prod; else nt = nt + prod;
          w = make_word(plq_pkg::ST_OK, ids[h], h, take, cl, req, nt);
          n++;
          fill_words++;
          if (!cl || !(req > 0 && head < NIL && n < 64 &&
                       (op == plq_pkg::OP_LIMIT || total > 0))) w.last = 1'b1;
          expected_words.push_back(w);
          if (!cl) break;
        end
        if (n == 0) begin
          w = make_word(plq_pkg::ST_OK, '0, '0, '0, '0, req, '0);
          w.last = 1'b1;
          expected_words.push_back(w);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    level_word_t got, want;
    if (rst) begin
      for (int i = 0; i < 64; i++) queued[i] = 1'b0;
      head = NIL; tail = NIL; count = 0; total = 0; lprice = 0; lside = 0;
      expected_words.delete();
      fail_count = 0;
      fill_words = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;       got.id = m_tdata[30:0];
        got.slot = m_tdata[36:31];  got.fvol = m_tdata[60:37];
        got.closed = m_tdata[61];   got.left = m_tdata[85:62];
        got.notional = m_tdata[149:86]; got.orders = m_tdata[156:150];
        got.lvol = m_tdata[186:157]; got.empty = m_tdata[187];
        got.lprice = m_tdata[219:188]; got.last = m_tlast;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            $display("  status %0d/%0d id %0d/%0d slot %0d/%0d fvol %0d/%0d",
                     want.status, got.status, want.id, got.id, want.slot,
                     got.slot, want.fvol, got.fvol);
            $display("  left %0d/%0d notional %0d/%0d orders %0d/%0d vol %0d/%0d",
                     want.left, got.left, $signed(want.notional),
                     $signed(got.notional), want.orders, got.orders,
                     want.lvol, got.lvol);
            fail_count++;
          end
        end
      end
      // Requests are predicted after the result check, so same-edge words stay ordered.
      if (s_tvalid && s_tready) predict_request(plq_pkg::op_t'(s_tuser), s_tdata);
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the price level order queue.
// ----------------------------------------------------------------------------
// A directed opening covers slot and field extremes, busy and empty slots,
// cancels at head, middle and tail, zero-volume orders and both fill modes on
// buy and sell levels. A random part then mostly builds and drains the level
// with realistic add/cancel/fill mixes. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [plq_pkg::InBits-1:0]    s_tdata = '0;
  logic [1:0]                    s_tuser = plq_pkg::OP_ADD;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [plq_pkg::OutBits-1:0]   m_tdata;
  logic [1:0]                    m_tuser;
  logic                          m_tlast;
  int                            fail_count, pending_words, fill_words;
  int                            burst_left = 0;
  int                            words_sent = 0;

  always #5 clk = ~clk;

  price_level_order_queue_top DUT (.*);

  plq_checker u_checker (.*);

  // The receiver alternates between stall-free stretches and random stalls.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (($time / 4000) % 3 == 0) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 2) != 0);
  end

  // Sends one request word; bursts of random length separated by random gaps.
  // Within a burst the next word replaces the accepted one at the falling edge.
  task automatic send_word(plq_pkg::op_t op, logic [5:0] sl, logic [30:0] id,
                           logic [31:0] pr, logic [23:0] vol, logic sd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tdata  <= {2'b0, sd, vol, pr, id, sl};
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_queue();
    s_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_vol();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(1, 200));
    endcase
  endfunction

  initial begin
    logic [5:0] sl;
    int k;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening.
    send_word(plq_pkg::OP_LIMIT, 0, 0, 0, 24'd5, 0);          // fill on an empty level
    send_word(plq_pkg::OP_CANCEL, 6'd63, 0, 0, 0, 0);         // cancel of a free slot
    send_word(plq_pkg::OP_ADD, 6'd0, 31'h7FFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 1'b0);
    send_word(plq_pkg::OP_ADD, 6'd0, 31'd1, 32'd7, 24'd1, 1'b1); // busy slot
    send_word(plq_pkg::OP_ADD, 6'd63, 31'd2, 32'd0, 24'd0, 1'b1); // zero volume order
    send_word(plq_pkg::OP_ADD, 6'd21, 31'h2AAAAAAA, 32'h55555555, 24'h555555, 1'b1);
    send_word(plq_pkg::OP_ADD, 6'd42, 31'h55555555, 32'hAAAAAAAA, 24'hAAAAAA, 1'b0);
    send_word(plq_pkg::OP_CANCEL, 6'd63, 0, 0, 0, 0);         // middle
    send_word(plq_pkg::OP_LIMIT, 0, 0, 0, 24'hFFFFFF, 0);     // closes the head at full scale
    send_word(plq_pkg::OP_MARKET, 0, 0, 0, 24'd3, 0);         // partial fill
    send_word(plq_pkg::OP_CANCEL, 6'd42, 0, 0, 0, 0);         // tail
    send_word(plq_pkg::OP_CANCEL, 6'd21, 0, 0, 0, 0);         // head, last order
    send_word(plq_pkg::OP_MARKET, 0, 0, 0, 24'd9, 0);
    send_word(plq_pkg::OP_ADD, 6'd5, 31'd10, 32'd1000, 24'd0, 1'b1); // sell level
    send_word(plq_pkg::OP_ADD, 6'd6, 31'd11, 32'd1, 24'd4, 1'b0);
    send_word(plq_pkg::OP_MARKET, 0, 0, 0, 24'd0, 0);         // zero request
    send_word(plq_pkg::OP_LIMIT, 0, 0, 0, 24'd10, 0);         // zero head closed, then overfill
    send_word(plq_pkg::OP_ADD, 6'd7, 31'd12, 32'd3, 24'd0, 1'b0);
    send_word(plq_pkg::OP_MARKET, 0, 0, 0, 24'd4, 0);         // market with no volume
    send_word(plq_pkg::OP_CANCEL, 6'd7, 0, 0, 0, 0);
    // Pause until the level has answered everything.
    drain_queue();

    // Random part: well-formed build/drain mixes with some noise.
    k = 0;
    while (k < 285) begin
      sl = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_word(plq_pkg::OP_ADD, sl, $urandom, $urandom, rand_vol(),
                              $urandom);
        4, 5: send_word(plq_pkg::OP_CANCEL, sl, $urandom, $urandom, $urandom, $urandom);
        6, 7: send_word(plq_pkg::OP_LIMIT, sl, $urandom, $urandom,
                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600),
                        $urandom);
        default: send_word(plq_pkg::OP_MARKET, sl, $urandom, $urandom,
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600),
                           $urandom);
      endcase
      // Once, send an add to every slot so long multi-order walks occur.
      if (k == 150) for (int i = 0; i < 64; i++)
        send_word(plq_pkg::OP_ADD, i[5:0], $urandom, $urandom, $urandom_range(0, 50),
                  $urandom);
      if (k == 151) send_word(plq_pkg::OP_LIMIT, 0, 0, 0, 24'hFFFFFF, 0);
      k++;
    end

    drain_queue();
    $display("Sent %0d request words; %0d fill result words predicted across both modes.",
             words_sent, fill_words);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d result words outstanding", pending_words);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/plq_pkg.sv
hw/rtl/price_level_order_queue_top.sv
sim/plq_checker.sv
sim/tb_top.sv
